[src/cfd_pkg.sv]
package cfd_pkg;

    typedef enum logic [1:0] {
        KIND_OPCODE  = 2'd0,
        KIND_COUNT   = 2'd1,
        KIND_LENGTH  = 2'd2,
        KIND_PAYLOAD = 2'd3
    } kind_t;

    localparam logic [31:0] SIZE_MAX = 32'hFFFF_FFFF;
    localparam logic [1:0]  LAST_LENGTH_POS = 2'd3;

    // Parser state carried from one item to the next.
    typedef struct packed {
        kind_t       phase;
        logic [1:0]  field_pos;
        logic [15:0] opcode;
        logic [15:0] args_left;
        logic [15:0] arg_count;
        logic [31:0] len_gather;
        logic [31:0] payload_left;
        logic [31:0] byte_total;
    } parse_state_t;

    // One tagged result item.
    typedef struct packed {
        logic [7:0]  data;
        kind_t       kind;
        logic [15:0] arg_number;
        logic [15:0] opcode;
        logic        cmd_end;
        logic [31:0] cmd_size;
    } tag_result_t;

endpackage

[src/cfd_step.sv]
module cfd_step import cfd_pkg::*; (
    input  parse_state_t state_cur,
    input  logic [7:0]   data_byte,
    output parse_state_t state_nxt,
    output tag_result_t  result
);

    logic [31:0] total_inc;
    logic [31:0] len_shift;
    logic [31:0] payload_dec;
    logic [15:0] args_dec;
    logic [15:0] args_full;
    logic [15:0] arg_num;
    logic        done;

    assign total_inc   = (state_cur.byte_total == SIZE_MAX) ? SIZE_MAX
                                                            : state_cur.byte_total + 32'd1;
    assign len_shift   = {state_cur.len_gather[23:0], data_byte};
    assign payload_dec = state_cur.payload_left - 32'd1;
    assign args_dec    = state_cur.args_left - 16'd1;
    assign args_full   = {state_cur.args_left[15:8], data_byte};

    always_comb begin
        state_nxt            = state_cur;
        state_nxt.byte_total = total_inc;
        arg_num              = 16'd0;
        done                 = 1'b0;

        case (state_cur.phase)
            KIND_OPCODE: begin
                if (state_cur.field_pos == 2'd0) begin
                    state_nxt.opcode    = {data_byte, 8'h00};
                    state_nxt.field_pos = 2'd1;
                end else begin
                    state_nxt.opcode    = {state_cur.opcode[15:8], data_byte};
                    state_nxt.field_pos = 2'd0;
                    state_nxt.phase     = KIND_COUNT;
                end
            end
            KIND_COUNT: begin
                if (state_cur.field_pos == 2'd0) begin
                    state_nxt.args_left = {data_byte, 8'h00};
                    state_nxt.field_pos = 2'd1;
                end else begin
                    state_nxt.args_left = args_full;
                    state_nxt.field_pos = 2'd0;
                    state_nxt.arg_count = 16'd0;
                    if (args_full == 16'd0) begin
                        done = 1'b1;
                    end else begin
                        state_nxt.phase = KIND_LENGTH;
                    end
                end
            end
            KIND_LENGTH: begin
                arg_num = state_cur.arg_count;
                if (state_cur.field_pos == LAST_LENGTH_POS) begin
                    state_nxt.field_pos  = 2'd0;
                    state_nxt.len_gather = 32'd0;
                    if (len_shift == 32'd0) begin
                        // An empty argument finishes on its last length byte.
                        state_nxt.args_left = args_dec;
                        state_nxt.arg_count = state_cur.arg_count + 16'd1;
                        done                = (args_dec == 16'd0);
                    end else begin
                        state_nxt.payload_left = len_shift;
                        state_nxt.phase        = KIND_PAYLOAD;
                    end
                end else begin
                    state_nxt.len_gather = len_shift;
                    state_nxt.field_pos  = state_cur.field_pos + 2'd1;
                end
            end
            KIND_PAYLOAD: begin
                arg_num                = state_cur.arg_count;
                state_nxt.payload_left = payload_dec;
                if (payload_dec == 32'd0) begin
                    state_nxt.args_left = args_dec;
                    state_nxt.arg_count = state_cur.arg_count + 16'd1;
                    state_nxt.phase     = KIND_LENGTH;
                    state_nxt.field_pos = 2'd0;
                    done                = (args_dec == 16'd0);
                end
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase

        result.data       = data_byte;
        result.kind       = state_cur.phase;
        result.arg_number = arg_num;
        result.opcode     = state_nxt.opcode;
        result.cmd_end    = done;
        result.cmd_size   = total_inc;

        if (done) begin
            state_nxt.phase      = KIND_OPCODE;
            state_nxt.field_pos  = 2'd0;
            state_nxt.byte_total = 32'd0;
        end
    end

endmodule

[src/command_frame_deframer.sv]
// Command frame deframer: tags each byte of a command stream (16-bit opcode, 16-bit
// argument count, then per argument a 32-bit length and its payload, all big-endian)
// with its field kind, argument index and opcode, and marks the byte that completes a
// command with tlast together with the command's total size, which saturates at
// 0xFFFFFFFF. One item is taken per cycle while the output register is empty or being
// read; each result appears in the cycle after its byte is accepted, held in a single
// output register that is refilled in the same cycle it is taken, so the parser state
// update is the only loop.
module command_frame_deframer import cfd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // byte_out[7:0], arg_number[23:8], opcode_value[39:24], command_size[71:40]
    output logic [71:0] m_tdata,
    output logic [1:0]  m_tuser,   // byte_kind[1:0]
    output logic        m_tlast    // command_end
);

    parse_state_t state_reg;
    parse_state_t state_next;
    tag_result_t  result_reg;
    tag_result_t  result_next;
    logic         valid_reg;
    logic         take;

    assign s_tready = !valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    cfd_step u_step (
        .state_cur (state_reg),
        .data_byte (s_tdata),
        .state_nxt (state_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (take) begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {result_reg.cmd_size, result_reg.opcode,
                       result_reg.arg_number, result_reg.data};
    assign m_tuser  = result_reg.kind;
    assign m_tlast  = result_reg.cmd_end;

endmodule
